// File: hw/rtl/lru_tub_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lru_tub_pkg;

	// Table geometry.
	localparam int NUM_UNITS   = 16;
	localparam int HANDLE_BITS = 32;
	localparam int UNIT_W      = $clog2(NUM_UNITS);
	localparam int CNT_W       = $clog2(NUM_UNITS + 1);

	// Port field widths.
	localparam int TEX_ID_W    = 32;
	localparam int OUT_UNIT_W  = 4;
	localparam int ACT_W       = 5;
	localparam logic [ACT_W-1:0] ACT_RESET = 5'd16;

	typedef logic [UNIT_W-1:0]      unit_idx_t;
	typedef logic [HANDLE_BITS-1:0] handle_t;
	typedef logic [CNT_W-1:0]       act_cnt_t;

	// Command broadcast to every unit cell.
	typedef struct packed {
		logic    look;
		logic    update;
		logic    miss;
		handle_t handle;
	} unit_cmd_t;

	// Signals that ripple from one recency cell to the next.
	typedef struct packed {
		logic      taken;
		unit_idx_t victim;
		logic      found;
	} rec_link_t;

	// Command broadcast to every recency cell.
	typedef struct packed {
		logic      update;
		unit_idx_t unit;
		act_cnt_t  act;
	} rec_cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/lru_texture_unit_binder_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// LRU texture unit binder. Each transfer on the slave stream names a texture
// handle; the block answers with one transfer on the master stream giving the
// texture unit that now holds it, whether it was already resident, and whether
// the unit must be rebound. Hits are found among units below active_units;
// on a miss the least recently used active unit is taken and any stale copy of
// the handle elsewhere is invalidated. An item is accepted, then the per-unit
// tag compare and the victim search along the recency chain run, then the
// chain is updated and the output register, once free, is loaded. A new item
// can be accepted while the previous result still waits on the master side.
// The user writes active_units via the cfg channel only while idle (the block
// does not enforce it); zero is one, values above the unit count saturate.
module lru_texture_unit_binder_unit import lru_tub_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// Configuration: active_units.
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [ACT_W-1:0]    cfg_data,
	// Requests. s_tdata: [31:0] texture_id.
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [TEX_ID_W-1:0] s_tdata,
	// Results. m_tdata: [3:0] unit, [4] was_bound, [5] load_needed, [7:6] zero.
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [7:0]               m_tdata
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOOK = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	logic [1:0]            state_q;
	logic [ACT_W-1:0]      active_q;
	handle_t               handle_q;
	unit_idx_t             victim_s1;
	act_cnt_t              act_cnt;
	logic [NUM_UNITS-1:0]  match;
	logic [NUM_UNITS-1:0]  act_mask;
	logic                  hit;
	unit_idx_t             hit_unit;
	unit_idx_t             sel_unit;
	logic                  fire;
	logic                  out_valid_q;
	logic [OUT_UNIT_W-1:0] out_unit_q;
	logic                  out_hit_q;
	unit_cmd_t             ucmd;
	rec_cmd_t              rcmd;
	rec_link_t             link [NUM_UNITS+1];
	unit_idx_t             slot_unit [NUM_UNITS];

	// Configuration register.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACT_RESET;
		end else if (cfg_valid) begin
			active_q <= cfg_data;
		end
	end

	// Effective active count, clamped to one through the unit count.
	always_comb begin
		if (active_q == '0) begin
			act_cnt = CNT_W'(1);
		end else if (int'(active_q) > NUM_UNITS) begin
			act_cnt = CNT_W'(NUM_UNITS);
		end else begin
			act_cnt = CNT_W'(active_q);
		end
	end

	// Sequencer.
	assign s_tready = (state_q == ST_IDLE);
	assign fire     = (state_q == ST_UPD) && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request handle, kept for the compare and the write.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			handle_q <= HANDLE_BITS'(s_tdata);
		end
	end

	// Victim from the recency chain, captured in the lookup cycle.
	always_ff @(posedge clk) begin
		if (state_q == ST_LOOK) begin
			victim_s1 <= link[NUM_UNITS].victim;
		end
	end

	// Lowest active matching unit wins.
	always_comb begin
		hit_unit = '0;
		for (int i = NUM_UNITS - 1; i >= 0; i--) begin
			if (match[i] && act_mask[i]) begin
				hit_unit = UNIT_W'(i);
			end
		end
	end

	assign hit      = |(match & act_mask);
	assign sel_unit = hit ? hit_unit : victim_s1;

	// Commands to the cells.
	always_comb begin
		ucmd.look   = (state_q == ST_LOOK);
		ucmd.update = fire;
		ucmd.miss   = !hit;
		ucmd.handle = handle_q;
		rcmd.update = fire;
		rcmd.unit   = sel_unit;
		rcmd.act    = act_cnt;
	end

	// Unit table cells.
	for (genvar i = 0; i < NUM_UNITS; i++) begin : g_unit
		assign act_mask[i] = CNT_W'(i) < act_cnt;

		lru_tub_unit_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (ucmd),
			.sel     (sel_unit == UNIT_W'(i)),
			.match_q (match[i])
		);
	end

	// Recency chain, oldest slot first; the newest slot takes the chosen unit.
	assign link[0] = '{taken: 1'b0, victim: '0, found: 1'b0};

	for (genvar i = 0; i < NUM_UNITS; i++) begin : g_rec
		unit_idx_t next_unit;

		if (i == NUM_UNITS - 1) begin : g_last
			assign next_unit = sel_unit;
		end else begin : g_mid
			assign next_unit = slot_unit[i+1];
		end

		lru_tub_rec_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (UNIT_W'(i)),
			.cmd       (rcmd),
			.link_in   (link[i]),
			.link_out  (link[i+1]),
			.next_unit (next_unit),
			.unit_q    (slot_unit[i])
		);
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_unit_q <= OUT_UNIT_W'(sel_unit);
			out_hit_q  <= hit;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, !out_hit_q, out_hit_q, out_unit_q};

endmodule

`default_nettype wire

// File: hw/rtl/lru_tub_unit_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module lru_tub_unit_cell import lru_tub_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire unit_cmd_t cmd,
	input  wire logic      sel,
	output logic           match_q
);

	handle_t handle_q;
	logic    valid_q;

	// Valid mark: reset clears it; a miss sets it on load, drops it on a stale copy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (cmd.look) begin
				match_q <= valid_q && (handle_q == cmd.handle);
			end
			if (cmd.update && cmd.miss) begin
				if (sel) begin
					valid_q <= 1'b1;
				end else if (match_q) begin
					valid_q <= 1'b0;
				end
			end
		end
	end

	// The handle itself needs no reset; it is read only behind the valid mark.
	always_ff @(posedge clk) begin
		if (cmd.update && cmd.miss && sel) begin
			handle_q <= cmd.handle;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/lru_tub_rec_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module lru_tub_rec_cell import lru_tub_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire unit_idx_t idx,
	input  wire rec_cmd_t  cmd,
	input  wire rec_link_t link_in,
	output rec_link_t      link_out,
	input  wire unit_idx_t next_unit,
	output unit_idx_t      unit_q
);

	logic eligible;
	logic pick;
	logic here;

	// Victim search: the first slot, oldest first, that holds an active unit.
	assign eligible = {1'b0, unit_q} < cmd.act;
	assign pick     = eligible && !link_in.taken;

	// Position search: this slot and every later one shift toward the old end.
	assign here = link_in.found || (unit_q == cmd.unit);

	always_comb begin
		link_out.taken  = link_in.taken || eligible;
		link_out.victim = pick ? unit_q : link_in.victim;
		link_out.found  = here;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q <= idx;
		end else if (cmd.update && here) begin
			unit_q <= next_unit;
		end
	end

endmodule

`default_nettype wire
